### hdl/efba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package efba_pkg;

   localparam int MAX_BLOCKS = 255;
   localparam int ADDR_W     = 32;
   localparam int BYTES_W    = 13;
   localparam int COUNT_W    = 8;
   localparam int INDEX_W    = 8;
   // offset inside the chunk is below 8191 * 255
   localparam int OFFSET_W   = 21;
   localparam int CHUNK_W    = BYTES_W + COUNT_W;

   // request modes
   localparam logic [1:0] MODE_ACQUIRE = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_QUERY   = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_EMPTY      = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_MISALIGNED = 3'd3;
   localparam logic [2:0] ST_OUTSIDE    = 3'd4;

   // ownership codes
   localparam logic [1:0] OWN_BEFORE = 2'd0;
   localparam logic [1:0] OWN_INSIDE = 2'd1;
   localparam logic [1:0] OWN_AFTER  = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_BASE  = 2'd0;
   localparam logic [1:0] CSR_BYTES = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;

   localparam logic [ADDR_W-1:0]  RESET_BASE  = '0;
   localparam logic [BYTES_W-1:0] RESET_BYTES = 13'd16;
   localparam logic [COUNT_W-1:0] RESET_COUNT = 8'd255;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [INDEX_W-1:0] block_index;
      logic [ADDR_W-1:0]  block_address;
      logic [1:0]         owner;
      logic [COUNT_W-1:0] free_left;
   } rsp_type;

   // effective geometry
   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [BYTES_W-1:0] bytes;
      logic [COUNT_W-1:0] count;
      logic [CHUNK_W-1:0] chunk;
   } cfg_type;

   // list reformat pulse
   typedef struct packed {
      logic               hit;
      logic [COUNT_W-1:0] count;
   } fmt_type;

   // classified request between front and back
   typedef struct packed {
      logic [1:0]          mode;
      logic [1:0]          owner;
      logic [OFFSET_W-1:0] offset;
   } job_type;

   function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] b);
      eff_bytes = (b == '0) ? BYTES_W'(1) : b;
   endfunction

   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] r;
      r = c;
      if (r < COUNT_W'(2)) r = COUNT_W'(2);
      if (r > COUNT_W'(MAX_BLOCKS)) r = COUNT_W'(MAX_BLOCKS);
      eff_count = r;
   endfunction

endpackage
`default_nettype wire

### hdl/embedded_free_list_block_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Block allocator for one chunk of up to 255 equal blocks, kept as a singly
// linked free list. Push a request (acquire, release or ownership query) and
// pop exactly one response per request, in order. Acquire hands out the head
// block; release maps an address back to a block index and relinks it; query
// tells whether an address lies before, inside or after the chunk. Errors are
// reported in the status field and leave the list untouched. A request
// passes the input stage and the two-entry job queue, then the back end
// steps through its states and writes the response to the response queue;
// a release inside the chunk waits there for the 8-step bit-serial offset
// divider. The back end takes the next job only after it has written the
// last response, and waits while both response slots are taken; the front
// stage and its two-entry queue accept the next request while the back end
// works. Writing block_count reformats the list at once (no clearing pass);
// base_address and block_bytes writes change the geometry only. Program
// registers only while no request is outstanding.
module embedded_free_list_block_allocator_core
   import efba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request queue
   input  logic              req_push,
   output logic              req_full,
   input  req_type           req_data,
   // response queue
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsp_type           rsp_data,
   // register writes
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   logic [ADDR_W-1:0]  base_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [CHUNK_W-1:0] chunk_ff;   // chunk size, registered off the multiply
   cfg_type            cfg;
   fmt_type            fmt;
   logic               job_valid;
   job_type            job;
   logic               job_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= RESET_BASE;
         bytes_ff <= RESET_BYTES;
         count_ff <= RESET_COUNT;
         chunk_ff <= CHUNK_W'(eff_bytes(RESET_BYTES)) * CHUNK_W'(eff_count(RESET_COUNT));
      end else begin
         chunk_ff <= CHUNK_W'(cfg.bytes) * CHUNK_W'(cfg.count);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BASE:  base_ff  <= csr_wdata;
               CSR_BYTES: bytes_ff <= csr_wdata[BYTES_W-1:0];
               CSR_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // zero size acts as one, count clamped to the legal range
   assign cfg.base  = base_ff;
   assign cfg.bytes = eff_bytes(bytes_ff);
   assign cfg.count = eff_count(count_ff);
   assign cfg.chunk = chunk_ff;

   // a block_count write restores the formatted list
   assign fmt.hit   = csr_write_enable && (csr_index == CSR_COUNT);
   assign fmt.count = eff_count(csr_wdata[COUNT_W-1:0]);

   efba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   efba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fmt       (fmt),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### hdl/efba_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle; quotient known to fit INDEX_W bits
module efba_div
   import efba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OFFSET_W-1:0] dividend,
   input  logic [BYTES_W-1:0]  divisor,
   output logic                done,
   output logic [INDEX_W-1:0]  quot,
   output logic                rem_zero
);

   localparam int DIV_W = BYTES_W + INDEX_W - 1;
   localparam logic [2:0] LAST_STEP = 3'(INDEX_W - 1);

   logic                busy_ff;
   logic                done_ff;
   logic [2:0]          step_ff;
   logic [OFFSET_W-1:0] rem_ff;
   logic [DIV_W-1:0]    dsr_ff;
   logic [INDEX_W-1:0]  quot_ff;
   logic                ge;

   assign ge = rem_ff >= OFFSET_W'(dsr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend;
         dsr_ff  <= {divisor, {(INDEX_W-1){1'b0}}};
         quot_ff <= '0;
      end else if (busy_ff) begin
         if (ge) rem_ff <= rem_ff - OFFSET_W'(dsr_ff);
         dsr_ff  <= dsr_ff >> 1;
         quot_ff <= {quot_ff[INDEX_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quot     = quot_ff;
   assign rem_zero = (rem_ff == '0);

endmodule
`default_nettype wire

### hdl/efba_front.sv
`timescale 1ns / 1ps
`default_nettype none
// input stage, chunk classification, two-entry job queue
module efba_front
   import efba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    job_valid,
   output job_type job,
   input  logic    job_pop
);

   req_type          stage_ff;
   logic             stage_vld_ff;
   job_type          que_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       cnt_ff;
   logic             que_full;
   logic             accept;
   logic             move;
   logic [ADDR_W:0]  chunk_end;
   logic [ADDR_W-1:0] offset_full;
   job_type          job_new;

   assign que_full = (cnt_ff == 2'd2);
   assign req_full = stage_vld_ff && que_full;
   assign accept   = req_push && !req_full;
   assign move     = stage_vld_ff && !que_full;

   // end of chunk without wrap
   assign chunk_end   = {1'b0, cfg.base} + (ADDR_W+1)'(cfg.chunk);
   assign offset_full = stage_ff.address - cfg.base;

   always_comb begin
      job_new.mode   = stage_ff.mode;
      job_new.offset = offset_full[OFFSET_W-1:0];
      if (stage_ff.address < cfg.base) begin
         job_new.owner = OWN_BEFORE;
      end else if ({1'b0, stage_ff.address} >= chunk_end) begin
         job_new.owner = OWN_AFTER;
      end else begin
         job_new.owner = OWN_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (accept) stage_vld_ff <= 1'b1;
         else if (move) stage_vld_ff <= 1'b0;
         if (move) wr_ptr_ff <= !wr_ptr_ff;
         if (job_pop) rd_ptr_ff <= !rd_ptr_ff;
         if (move && !job_pop) cnt_ff <= cnt_ff + 2'd1;
         else if (!move && job_pop) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) stage_ff <= req_data;
      if (move) que_ff[wr_ptr_ff] <= job_new;
   end

   assign job_valid = (cnt_ff != '0);
   assign job       = que_ff[rd_ptr_ff];

endmodule
`default_nettype wire

### hdl/efba_back.sv
`timescale 1ns / 1ps
`default_nettype none
// list engine: link memory, head and free count, result queue
module efba_back
   import efba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  fmt_type fmt,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int LINKS = 1 << INDEX_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LINK = 5'b00010,
      S_DIV  = 5'b00100,
      S_MUL  = 5'b01000,
      S_PUSH = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [INDEX_W-1:0] head_ff, head_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [2:0]         status_ff, status_in;
   logic [1:0]         owner_ff, owner_in;
   logic               addr_en_ff, addr_en_in;
   logic [CHUNK_W-1:0] prod_ff;

   logic [INDEX_W-1:0] link_mem [LINKS];
   logic [LINKS-1:0]   link_vld_ff;
   logic [INDEX_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic               mem_we;

   logic               div_start;
   logic               div_done;
   logic [INDEX_W-1:0] div_quot;
   logic               div_rem_zero;

   rsp_type            out_ff [2];
   logic               out_wr_ff;
   logic               out_rd_ff;
   logic [1:0]         out_cnt_ff;
   logic               out_push;
   logic               out_pop;
   logic               start;
   rsp_type            rsp_new;

   efba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (job.offset),
      .divisor  (cfg.bytes),
      .done     (div_done),
      .quot     (div_quot),
      .rem_zero (div_rem_zero)
   );

   assign start   = (state_ff == S_IDLE) && job_valid && (out_cnt_ff != 2'd2);
   assign job_pop = start;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      free_in    = free_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      owner_in   = owner_ff;
      addr_en_in = addr_en_ff;
      mem_we     = 1'b0;
      div_start  = 1'b0;
      out_push   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               owner_in   = OWN_BEFORE;
               idx_in     = '0;
               addr_en_in = 1'b0;
               status_in  = ST_OK;
               case (job.mode)
                  MODE_ACQUIRE: begin
                     if (free_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_MUL;
                     end else begin
                        idx_in   = head_ff;
                        state_in = S_LINK;
                     end
                  end
                  MODE_RELEASE: begin
                     owner_in = job.owner;
                     if (job.owner != OWN_INSIDE) begin
                        status_in = ST_OUTSIDE;
                        state_in  = S_MUL;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                     owner_in = job.owner;
                     state_in = S_MUL;
                  end
               endcase
            end
         end
         S_LINK: begin
            // untouched entries still hold their formatted successor
            head_in    = rd_vld_ff ? rd_data_ff : idx_ff + INDEX_W'(1);
            free_in    = free_ff - COUNT_W'(1);
            addr_en_in = 1'b1;
            state_in   = S_MUL;
         end
         S_DIV: begin
            if (div_done) begin
               if (!div_rem_zero) begin
                  status_in = ST_MISALIGNED;
               end else if (free_ff >= cfg.count) begin
                  status_in = ST_FULL;
               end else begin
                  mem_we     = 1'b1;
                  head_in    = div_quot;
                  free_in    = free_ff + COUNT_W'(1);
                  idx_in     = div_quot;
                  addr_en_in = 1'b1;
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_PUSH;
         end
         S_PUSH: begin
            out_push = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         free_ff  <= eff_count(RESET_COUNT);
      end else if (fmt.hit) begin
         state_ff <= state_in;
         head_ff  <= '0;
         free_ff  <= fmt.count;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      owner_ff   <= owner_in;
      addr_en_ff <= addr_en_in;
      prod_ff    <= CHUNK_W'(idx_ff) * CHUNK_W'(cfg.bytes);
   end

   // link memory, read at the head every cycle
   always_ff @(posedge clock) begin
      if (mem_we) link_mem[div_quot] <= head_ff;
      rd_data_ff <= link_mem[head_ff];
      rd_vld_ff  <= link_vld_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || fmt.hit) begin
         link_vld_ff <= '0;
      end else if (mem_we) begin
         link_vld_ff[div_quot] <= 1'b1;
      end
   end

   always_comb begin
      rsp_new.status        = status_ff;
      rsp_new.block_index   = idx_ff;
      rsp_new.block_address = addr_en_ff ? cfg.base + ADDR_W'(prod_ff) : '0;
      rsp_new.owner         = owner_ff;
      rsp_new.free_left     = free_ff;
   end

   assign out_pop = rsp_pop && (out_cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= '0;
      end else begin
         if (out_push) out_wr_ff <= !out_wr_ff;
         if (out_pop) out_rd_ff <= !out_rd_ff;
         if (out_push && !out_pop) out_cnt_ff <= out_cnt_ff + 2'd1;
         else if (!out_push && out_pop) out_cnt_ff <= out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) out_ff[out_wr_ff] <= rsp_new;
   end

   assign rsp_empty = (out_cnt_ff == '0);
   assign rsp_data  = out_ff[out_rd_ff];

endmodule
`default_nettype wire

### tb/block_allocator_checker.sv
`timescale 1ns / 1ps
module block_allocator_checker
   import efba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  req_type           req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  rsp_type           rsp_data,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [ADDR_W-1:0] csr_wdata,
   output int                outstanding,
   output int                mismatches
);

   // own copy of the free list and the chunk geometry
   logic [INDEX_W-1:0] link_tbl [0:255];
   logic [INDEX_W-1:0] head_slot;
   logic [COUNT_W-1:0] free_blocks;
   logic [ADDR_W-1:0]  chunk_base;
   logic [BYTES_W-1:0] raw_bytes;
   logic [COUNT_W-1:0] raw_count;

   rsp_type pending_outcomes [$];
   rsp_type want;
   int      fail_count = 0;

   assign mismatches = fail_count;

   function automatic logic [31:0] unit_bytes();
      return (raw_bytes == '0) ? 32'd1 : 32'(raw_bytes);
   endfunction

   function automatic logic [COUNT_W-1:0] live_count();
      if (raw_count < 8'd2) return 8'd2;
      if (raw_count > 8'(MAX_BLOCKS)) return 8'(MAX_BLOCKS);
      return raw_count;
   endfunction

   function automatic void relink_all();
      for (int i = 0; i < 256; i++) link_tbl[i] = 8'(i + 1);
      head_slot   = '0;
      free_blocks = live_count();
   endfunction

   function automatic logic [1:0] locate(logic [ADDR_W-1:0] addr);
      logic [63:0] limit;
      limit = {32'd0, chunk_base} + {32'd0, unit_bytes()} * {56'd0, live_count()};
      if (addr < chunk_base) return OWN_BEFORE;
      if ({32'd0, addr} >= limit) return OWN_AFTER;
      return OWN_INSIDE;
   endfunction

   function automatic rsp_type predict_outcome(req_type r);
      rsp_type            o;
      logic [31:0]        offset;
      logic [INDEX_W-1:0] slot;
      o = '0;
      o.status = ST_OK;
      case (r.mode)
         MODE_ACQUIRE: begin
            if (free_blocks == '0) begin
               o.status = ST_EMPTY;
            end else begin
               slot            = head_slot;
               head_slot       = link_tbl[slot];
               free_blocks     = free_blocks - 8'd1;
               o.block_index   = slot;
               o.block_address = chunk_base + 32'(slot) * unit_bytes();
            end
         end
         MODE_RELEASE: begin
            o.owner = locate(r.address);
            if (o.owner != OWN_INSIDE) begin
               o.status = ST_OUTSIDE;
            end else begin
               offset = r.address - chunk_base;
               if (offset % unit_bytes() != 0) begin
                  o.status = ST_MISALIGNED;
               end else if (free_blocks >= live_count()) begin
                  o.status = ST_FULL;
               end else begin
                  slot            = 8'(offset / unit_bytes());
                  link_tbl[slot]  = head_slot;
                  head_slot       = slot;
                  free_blocks     = free_blocks + 8'd1;
                  o.block_index   = slot;
                  o.block_address = chunk_base + 32'(slot) * unit_bytes();
               end
            end
         end
         // query, and the spare mode behaves as one
         default: o.owner = locate(r.address);
      endcase
      o.free_left = free_blocks;
      return o;
   endfunction

   task automatic note_field(string label, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         $display("%0t: %s expected %0h got %0h", $time, label, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         chunk_base = RESET_BASE;
         raw_bytes  = RESET_BYTES;
         raw_count  = RESET_COUNT;
         relink_all();
         pending_outcomes.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BASE:  chunk_base = csr_wdata;
               CSR_BYTES: raw_bytes = csr_wdata[BYTES_W-1:0];
               CSR_COUNT: begin
                  raw_count = csr_wdata[COUNT_W-1:0];
                  relink_all();
               end
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (pending_outcomes.size() == 0) begin
               fail_count++;
               $display("%0t: response with no request outstanding: expected none got %h",
                        $time, rsp_data);
            end else begin
               want = pending_outcomes.pop_front();
               note_field("status", 32'(want.status), 32'(rsp_data.status));
               note_field("block_index", 32'(want.block_index), 32'(rsp_data.block_index));
               note_field("block_address", want.block_address, rsp_data.block_address);
               note_field("owner", 32'(want.owner), 32'(rsp_data.owner));
               note_field("free_left", 32'(want.free_left), 32'(rsp_data.free_left));
            end
         end
         if (req_push && !req_full) pending_outcomes.push_back(predict_outcome(req_data));
      end
      outstanding <= pending_outcomes.size();
   end

endmodule

### tb/embedded_free_list_block_allocator_core_test.sv
`timescale 1ns / 1ps
module embedded_free_list_block_allocator_core_test;
   import efba_pkg::*;

   // spare codes the package leaves unnamed: mode 3 acts as a query,
   // register index 3 is ignored by the block
   localparam logic [1:0] MODE_SPARE  = 2'd3;
   localparam logic [1:0] CSR_SPARE   = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         ROUNDS      = 8;
   localparam int         PER_ROUND   = 119;
   localparam int         HOLD_CYCLES = 400;

   typedef enum logic [1:0] {POP_EVERY, POP_COIN, POP_SPARSE, POP_THIRD} pop_style_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   req_type           req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   rsp_type           rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [1:0]        csr_index = CSR_BASE;
   logic [ADDR_W-1:0] csr_wdata = '0;

   int outstanding;
   int error_total;
   int cycle_count = 0;

   // shadow geometry, only used to aim addresses at interesting spots
   logic [31:0] cur_base   = 32'd0;
   int unsigned cur_unit   = 16;
   int unsigned cur_blocks = 255;

   // sender burst state
   int burst_left = 0;
   bit steady     = 1'b0;
   int acq_pct    = 40;

   // long receiver hold-off: the stimulus bumps the request count, the
   // receiver serves it in its own process
   int            hold_requests = 0;
   int            holds_served  = 0;
   int            hold_left     = 0;
   int            rx_cycle      = 0;
   pop_style_type pop_style     = POP_EVERY;

   always #5 clock = ~clock;

   embedded_free_list_block_allocator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   block_allocator_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .outstanding      (outstanding),
      .mismatches       (error_total)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // response side: the pop pattern changes style every so often, and a
   // requested hold-off keeps pop low for a long stretch so that the
   // block backs up and raises full
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 97 == 0) pop_style = pop_style_type'($urandom_range(0, 3));
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_style)
               POP_EVERY:  rsp_pop <= 1'b1;
               POP_COIN:   rsp_pop <= ($urandom_range(0, 1) == 1);
               POP_SPARSE: rsp_pop <= ($urandom_range(0, 4) == 0);
               default:    rsp_pop <= (rx_cycle % 3 == 0);
            endcase
         end
      end
   end

   function automatic req_type mk(logic [1:0] m, logic [31:0] a);
      req_type r;
      r.mode    = m;
      r.address = a;
      return r;
   endfunction

   // called at a clock edge; returns at the edge where the request went in,
   // push left high so a following request goes straight on
   task automatic send_request(req_type r);
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
   endtask

   // bursts of random length separated by random gaps
   task automatic issue(req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            2:       gap = 20;
            default: gap = $urandom_range(1, 8);
         endcase
         if (gap != 0 && !steady) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_request(r);
   endtask

   // drop push, wait for every response, then let the divider drain
   task automatic settle();
      req_push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_reg(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_BASE:  cur_base = value;
         CSR_BYTES: cur_unit = (value[12:0] == 13'd0) ? 1 : value[12:0];
         CSR_COUNT: cur_blocks = (value[7:0] < 2) ? 2 : value[7:0];
         default: ;
      endcase
   endtask

   // addresses around the chunk edges, inside, misaligned or anywhere
   function automatic logic [31:0] edge_address();
      logic [63:0] chunk_end;
      logic [31:0] aligned;
      chunk_end = {32'd0, cur_base} + 64'(cur_unit) * 64'(cur_blocks);
      aligned   = cur_base + 32'($urandom_range(0, cur_blocks - 1) * cur_unit);
      case ($urandom_range(0, 7))
         0:       return cur_base - 32'd1;
         1:       return cur_base;
         2:       return chunk_end[31:0] - 32'd1;
         3:       return chunk_end[31:0];
         4:       return $urandom;
         5:       return aligned + ((cur_unit > 1) ? 32'($urandom_range(1, cur_unit - 1)) : 32'd0);
         6:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
         default: return aligned;
      endcase
   endfunction

   // acquire and well-aimed release traffic, the rest queries and releases
   // aimed at the chunk edges, misaligned or anywhere
   function automatic req_type next_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < acq_pct)
         return mk(MODE_ACQUIRE, $urandom);
      if (pick < acq_pct + 30)
         return mk(MODE_RELEASE,
                   cur_base + 32'($urandom_range(0, cur_blocks - 1) * cur_unit));
      if (pick < acq_pct + 40)
         return mk(MODE_RELEASE, edge_address());
      return mk(($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_QUERY, edge_address());
   endfunction

   initial begin
      int round;
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed, reset geometry: base 0, 16 byte blocks, 255 of them
      send_request(mk(MODE_ACQUIRE, 32'd0));
      send_request(mk(MODE_ACQUIRE, 32'd0));
      send_request(mk(MODE_RELEASE, 32'd16));
      send_request(mk(MODE_RELEASE, 32'd17));            // misaligned
      send_request(mk(MODE_RELEASE, 32'hFFFF_FFF0));     // past the chunk
      send_request(mk(MODE_RELEASE, 32'd0));             // list full again
      send_request(mk(MODE_RELEASE, 32'd0));             // release when full
      send_request(mk(MODE_SPARE, 32'd8));               // spare mode as query
      send_request(mk(MODE_QUERY, 32'd4080));            // first byte after
      send_request(mk(MODE_QUERY, 32'd4079));            // last byte inside
      send_request(mk(MODE_ACQUIRE, 32'hFFFF_FFFF));     // address ignored
      settle();

      // chunk end beyond 2^32, 4096 byte blocks, smallest count
      set_reg(CSR_BASE, 32'hFFFF_F000);
      set_reg(CSR_BYTES, 32'd4096);
      set_reg(CSR_COUNT, 32'd2);
      send_request(mk(MODE_QUERY, 32'd0));               // before
      send_request(mk(MODE_QUERY, 32'hFFFF_FFFF));       // inside, no wrap of end
      send_request(mk(MODE_RELEASE, 32'hFFFF_EFFF));     // before: outside
      send_request(mk(MODE_ACQUIRE, 32'd0));
      send_request(mk(MODE_ACQUIRE, 32'd0));             // address wraps to 0
      send_request(mk(MODE_ACQUIRE, 32'd0));             // empty
      send_request(mk(MODE_RELEASE, 32'hFFFF_F001));     // misaligned
      send_request(mk(MODE_RELEASE, 32'hFFFF_F000));
      settle();

      // block size 0 acts as 1, and the list is kept as it stands
      set_reg(CSR_BYTES, 32'd0);
      send_request(mk(MODE_RELEASE, 32'hFFFF_F001));
      send_request(mk(MODE_ACQUIRE, 32'd0));
      send_request(mk(MODE_RELEASE, 32'hFFFF_F002));     // after: outside

      // random rounds, each with its own geometry
      for (round = 0; round < ROUNDS; round++) begin
         settle();
         case (round)
            0: begin
               set_reg(CSR_BASE, $urandom);
               set_reg(CSR_BYTES, $urandom_range(1, 64));
               set_reg(CSR_COUNT, 32'd2);
            end
            1: begin
               set_reg(CSR_BASE, 32'd0);
               set_reg(CSR_BYTES, 32'd4096);
               set_reg(CSR_COUNT, 32'd255);
            end
            2: begin
               set_reg(CSR_BASE, $urandom);
               set_reg(CSR_BYTES, 32'd0);
               set_reg(CSR_COUNT, 32'd0);                // clamps to 2
            end
            3: begin
               set_reg(CSR_BASE, 32'hFFFF_FFFF);
               set_reg(CSR_BYTES, {19'($urandom_range(0, 32'h7FFFF)), 13'h1FFF});
               set_reg(CSR_COUNT, 32'd1);                // clamps to 2
            end
            5: begin
               // the receiver goes quiet while the sender keeps pushing
               set_reg(CSR_BASE, $urandom);
               set_reg(CSR_BYTES, 32'd16);
               set_reg(CSR_COUNT, 32'd255);
               hold_requests <= hold_requests + 1;
               steady = 1'b1;
            end
            6: begin
               set_reg(CSR_SPARE, $urandom);
               set_reg(CSR_BASE, $urandom);
               set_reg(CSR_BYTES, $urandom);
               set_reg(CSR_COUNT, $urandom);
            end
            7: begin
               set_reg(CSR_BASE, 32'd0);
               set_reg(CSR_BYTES, 32'd1);
               set_reg(CSR_COUNT, 32'd8);
            end
            default: begin
               set_reg(CSR_BASE, $urandom);
               set_reg(CSR_BYTES, $urandom_range(1, 4096));
               set_reg(CSR_COUNT, $urandom_range(2, 255));
            end
         endcase
         for (n = 0; n < PER_ROUND; n++) begin
            if (n % 25 == 0) begin
               case ($urandom_range(0, 2))
                  0:       acq_pct = 15;
                  1:       acq_pct = 40;
                  default: acq_pct = 65;
               endcase
            end
            if (n == 100) steady = 1'b0;
            // geometry change part way through, list left as it is
            if (n == PER_ROUND / 2 && $urandom_range(0, 1)) begin
               settle();
               if ($urandom_range(0, 1)) set_reg(CSR_BASE, $urandom);
               else set_reg(CSR_BYTES, $urandom_range(0, 300));
            end
            issue(next_request());
         end
      end

      settle();
      if (error_total == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/efba_pkg.sv
hdl/efba_div.sv
hdl/efba_front.sv
hdl/efba_back.sv
hdl/embedded_free_list_block_allocator_core.sv
tb/block_allocator_checker.sv
tb/embedded_free_list_block_allocator_core_test.sv
